// ===== rtl/bcra_pkg.sv =====
`timescale 1ns / 1ps
package bcra_pkg;

  localparam int MAX_FRAMES = 4096;
  localparam int WORD_BITS  = 64;
  localparam int MAP_WORDS  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int CNT_W      = FRAME_W + 1;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WORD_AW    = FRAME_W - BIT_W;

  localparam int HEAP_W     = 13;
  localparam int FIRST_W    = 12;
  localparam int COUNT_W    = 13;
  localparam int START_W    = 12;
  localparam int STATUS_W   = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BAD    = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic                 rd_en;
    logic                 wr_en;
    logic [WORD_AW-1:0]   addr;
    logic [WORD_BITS-1:0] wdata;
  } mem_req_t;

endpackage

// ===== rtl/bcra_ram.sv =====
`timescale 1ns / 1ps
module bcra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bcra_bitmap.sv =====
`timescale 1ns / 1ps
module bcra_bitmap (
  input  logic                           clk,
  input  logic                           rst,
  input  bcra_pkg::mem_req_t             req,
  output logic [bcra_pkg::WORD_BITS-1:0] rd_word
);

  logic [bcra_pkg::MAP_WORDS-1:0] valid;
  logic                           rd_valid;
  logic [bcra_pkg::WORD_BITS-1:0] rdata;

  bcra_ram #(
    .WIDTH(bcra_pkg::WORD_BITS),
    .DEPTH(bcra_pkg::MAP_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (req.wr_en),
    .waddr(req.addr),
    .wdata(req.wdata),
    .re   (req.rd_en),
    .raddr(req.addr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid <= valid[req.addr];
      end
    end
  end

  // unwritten words read as all free
  assign rd_word = rd_valid ? rdata : '0;

endmodule

// ===== rtl/bcra_mask.sv =====
`timescale 1ns / 1ps
module bcra_mask (
  input  logic [bcra_pkg::WORD_AW-1:0]   word,
  input  logic [bcra_pkg::FRAME_W-1:0]   lo,
  input  logic [bcra_pkg::FRAME_W-1:0]   hi,
  output logic [bcra_pkg::WORD_BITS-1:0] mask
);

  logic [bcra_pkg::BIT_W-1:0] lo_b;
  logic [bcra_pkg::BIT_W-1:0] hi_b;

  always_comb begin
    lo_b = (word == lo[bcra_pkg::FRAME_W-1:bcra_pkg::BIT_W]) ?
           lo[bcra_pkg::BIT_W-1:0] : '0;
    hi_b = (word == hi[bcra_pkg::FRAME_W-1:bcra_pkg::BIT_W]) ?
           hi[bcra_pkg::BIT_W-1:0] : '1;
    mask = ({bcra_pkg::WORD_BITS{1'b1}} << lo_b) &
           ({bcra_pkg::WORD_BITS{1'b1}} >> (~hi_b));
  end

endmodule

// ===== rtl/bitmap_contiguous_run_allocator.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Ports                         Payload
// cfg       in         cfg_wr_en, cfg_wr_data[12:0]  heap_frames
// s         in         s_tvalid/s_tready/s_tdata     tdata: first_frame, frame_count
//                      s_tuser                       tuser: command
// m         out        m_tvalid/m_tready/m_tdata     tdata: status, start_frame
//
// One item at a time. A rejected request goes straight to the finish state. An
// allocate walks the bitmap one frame per cycle from the rover, pausing in a read
// state on each word entered, then marks the run with a read and a write per word.
// A free reads each word spanned to check it, then reads and writes each word to clear it.
// Reset clears the per-word valid flags at once, no clearing pass. A stalled result
// stays in the output register while the next request is taken.
module bitmap_contiguous_run_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [11:0] first_frame, [24:12] frame_count
  input  logic [0:0]  s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [1:0] status, [13:2] start_frame
);

  localparam int FW = bcra_pkg::FRAME_W;
  localparam int CW = bcra_pkg::CNT_W;
  localparam int BW = bcra_pkg::BIT_W;
  localparam int AW = bcra_pkg::WORD_AW;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN_RD = 6'b000010,
    S_SCAN    = 6'b000100,
    S_RMW_RD  = 6'b001000,
    S_RMW_WR  = 6'b010000,
    S_FINISH  = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    OP_CHECK = 3'b001,
    OP_SET   = 3'b010,
    OP_CLEAR = 3'b100
  } op_t;

  state_t                       state;
  op_t                          mode;
  logic [bcra_pkg::HEAP_W-1:0]  heap_cfg;
  logic [CW-1:0]                cnt;
  logic [FW-1:0]                pos;
  logic [CW-1:0]                run;
  logic [CW-1:0]                iter;
  logic [FW-1:0]                rover;
  logic [FW-1:0]                lo;
  logic [FW-1:0]                hi;
  logic [AW-1:0]                word;
  bcra_pkg::status_t            status;
  logic [FW-1:0]                start;
  logic [bcra_pkg::STATUS_W-1:0] out_status;
  logic [bcra_pkg::START_W-1:0] out_start;

  logic [CW-1:0]                heap;
  logic [bcra_pkg::FIRST_W-1:0] in_first;
  logic [bcra_pkg::COUNT_W-1:0] in_count;
  bcra_pkg::cmd_t               in_cmd;
  logic                         in_bad;
  logic [31:0]                  free_end;
  logic                         accept;
  logic                         out_free;

  logic [bcra_pkg::WORD_BITS-1:0] rd_word;
  logic [bcra_pkg::WORD_BITS-1:0] mask;
  bcra_pkg::mem_req_t             req;
  logic                           scan_bit;
  logic [CW-1:0]                  run_n;
  logic [CW-1:0]                  pos_inc;
  logic [CW-1:0]                  iter_n;
  logic                           last_word;

  assign heap     = (32'(heap_cfg) > bcra_pkg::MAX_FRAMES) ?
                    CW'(bcra_pkg::MAX_FRAMES) : CW'(heap_cfg);
  assign in_first = s_tdata[11:0];
  assign in_count = s_tdata[24:12];
  assign in_cmd   = bcra_pkg::cmd_t'(s_tuser[0]);
  assign free_end = 32'(in_first) + 32'(in_count);
  assign in_bad   = (in_count == '0) ||
                    ((in_cmd == bcra_pkg::CMD_ALLOC) ? (32'(in_count) > 32'(heap))
                                                     : (free_end > 32'(heap)));
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign scan_bit  = rd_word[pos[BW-1:0]];
  assign run_n     = scan_bit ? '0 : run + 1'b1;
  assign pos_inc   = {1'b0, pos} + 1'b1;
  assign iter_n    = iter + 1'b1;
  assign last_word = (word == hi[FW-1:BW]);

  bcra_mask u_mask (
    .word(word),
    .lo  (lo),
    .hi  (hi),
    .mask(mask)
  );

  bcra_bitmap u_bitmap (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rd_word(rd_word)
  );

  always_comb begin
    req.rd_en = (state == S_SCAN_RD) || (state == S_RMW_RD);
    req.wr_en = (state == S_RMW_WR) && (mode != OP_CHECK);
    req.addr  = (state == S_SCAN_RD) ? pos[FW-1:BW] : word;
    req.wdata = (mode == OP_SET) ? (rd_word | mask) : (rd_word & ~mask);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mode     <= OP_CHECK;
      heap_cfg <= bcra_pkg::HEAP_W'(4096);
      rover    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        heap_cfg <= cfg_wr_data;
      end
      if ((state == S_FINISH) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            start <= '0;
            cnt   <= CW'(in_count);
            if (in_bad) begin
              status <= bcra_pkg::ST_BAD;
              state  <= S_FINISH;
            end else if (in_cmd == bcra_pkg::CMD_ALLOC) begin
              pos   <= ({1'b0, rover} < heap) ? rover : '0;
              run   <= '0;
              iter  <= '0;
              state <= S_SCAN_RD;
            end else begin
              lo    <= FW'(in_first);
              hi    <= FW'(free_end - 32'd1);
              word  <= in_first[FW-1:BW];
              mode  <= OP_CHECK;
              state <= S_RMW_RD;
            end
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (run_n == cnt) begin
            lo    <= FW'(pos_inc - cnt);
            hi    <= pos;
            start <= FW'(pos_inc - cnt);
            word  <= AW'(FW'(pos_inc - cnt) >> BW);
            rover <= (pos_inc == heap) ? '0 : FW'(pos_inc);
            mode  <= OP_SET;
            state <= S_RMW_RD;
          end else if (iter_n == heap) begin
            status <= bcra_pkg::ST_FULL;
            state  <= S_FINISH;
          end else begin
            iter <= iter_n;
            if (pos_inc == heap) begin
              pos   <= '0;
              run   <= '0;
              state <= S_SCAN_RD;
            end else begin
              pos <= FW'(pos_inc);
              run <= run_n;
              if (pos_inc[BW-1:0] == '0) begin
                state <= S_SCAN_RD;
              end
            end
          end
        end
        S_RMW_RD: begin
          state <= S_RMW_WR;
        end
        S_RMW_WR: begin
          if (mode == OP_CHECK) begin
            if ((rd_word & mask) != mask) begin
              status <= bcra_pkg::ST_UNUSED;
              state  <= S_FINISH;
            end else if (last_word) begin
              mode  <= OP_CLEAR;
              word  <= lo[FW-1:BW];
              state <= S_RMW_RD;
            end else begin
              word  <= word + 1'b1;
              state <= S_RMW_RD;
            end
          end else if (last_word) begin
            status <= bcra_pkg::ST_OK;
            state  <= S_FINISH;
          end else begin
            word  <= word + 1'b1;
            state <= S_RMW_RD;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_status <= status;
            out_start  <= (status == bcra_pkg::ST_OK) ? bcra_pkg::START_W'(start) : '0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {2'b00, out_start, out_status};

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("request taken while a request is in progress");

  a_fail_no_start: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_status != bcra_pkg::ST_OK) |-> out_start == '0)
    else $error("start frame reported on a failed request");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (run <= iter + 1'b1) && (run < cnt))
    else $error("free run count out of bounds");

  a_word_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RMW_RD) |-> (word >= lo[FW-1:BW]) && (word <= hi[FW-1:BW]))
    else $error("bitmap word outside the run");

  a_finish_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) && out_free |=> m_tvalid && s_tready)
    else $error("result not loaded on finish");
`endif

endmodule

// ===== verif/tb_bitmap_contiguous_run_allocator.sv =====
`timescale 1ns / 1ps
module tb_bitmap_contiguous_run_allocator;
  import bcra_pkg::*;

  localparam int STALL_LIMIT = 40000;

  typedef struct {
    cmd_t             cmd;
    logic [FIRST_W-1:0] first;
    logic [COUNT_W-1:0] count;
  } frame_request_t;

  typedef struct {
    status_t            status;
    logic [START_W-1:0] start;
  } alloc_reply_t;

  typedef struct {
    int first;
    int count;
  } frame_run_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [HEAP_W-1:0]   cfg_wr_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [31:0]         s_tdata = '0;   // [11:0] first_frame, [24:12] frame_count
  logic [0:0]          s_tuser = '0;   // [0] command
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [15:0]         m_tdata;        // [1:0] status, [13:2] start_frame

  frame_request_t request_queue[$];
  alloc_reply_t   awaited_replies[$];
  frame_run_t     live_runs[$];

  bit usage_map [MAX_FRAMES];
  int search_rover = 0;
  int heap_frames_cfg = 4096;
  int status_tally [4] = '{0, 0, 0, 0};

  int  send_idle_pct = 6;
  int  recv_idle_pct = 63;
  int  error_count = 0;
  int  stall_cycles = 0;
  int  request_total = 0;
  logic req_fire = 1'b0;

  int phase_heap  [9] = '{100, 0, 1, 8191, 64, 257, 13, 4096, 200};
  int phase_items [9] = '{150, 10, 30, 40, 150, 150, 100, 30, 200};

  bitmap_contiguous_run_allocator u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(string what);
    if (error_count < 50) $display("MISMATCH at %0t: %s", $time, what);
    error_count++;
  endtask

  // Next-fit scan from the rover; the free-run count restarts at the wrap.
  task automatic apply_frame_request(cmd_t cmd, logic [FIRST_W-1:0] first_in,
                                     logic [COUNT_W-1:0] count_in);
    int heap, first, count, pos, run, i, start;
    bit found;
    status_t st;
    heap  = (heap_frames_cfg > MAX_FRAMES) ? MAX_FRAMES : heap_frames_cfg;
    first = first_in;
    count = count_in;
    st    = ST_OK;
    start = 0;
    found = 1'b0;
    if (cmd == CMD_ALLOC) begin
      if (count == 0 || count > heap) begin
        st = ST_BAD;
      end else begin
        pos = (search_rover < heap) ? search_rover : 0;
        run = 0;
        for (i = 0; i < heap; i++) begin
          if (usage_map[pos]) run = 0;
          else run++;
          if (run == count) begin
            found = 1'b1;
            break;
          end
          pos++;
          if (pos == heap) begin
            pos = 0;
            run = 0;
          end
        end
        if (found) begin
          start = pos + 1 - count;
          for (i = 0; i < count; i++) usage_map[start + i] = 1'b1;
          search_rover = (pos + 1 == heap) ? 0 : pos + 1;
          live_runs.push_back('{first: start, count: count});
        end else begin
          st = ST_FULL;
        end
      end
    end else begin
      if (count == 0 || first + count > heap) begin
        st = ST_BAD;
      end else begin
        for (i = 0; i < count; i++) begin
          if (!usage_map[first + i]) begin
            st = ST_UNUSED;
            break;
          end
        end
        if (st == ST_OK)
          for (i = 0; i < count; i++) usage_map[first + i] = 1'b0;
      end
    end
    status_tally[st]++;
    request_total++;
    awaited_replies.push_back('{status: st, start: START_W'(start)});
  endtask

  task automatic queue_request(cmd_t cmd, int first, int count);
    request_queue.push_back('{cmd: cmd, first: FIRST_W'(first), count: COUNT_W'(count)});
  endtask

  task automatic queue_random_request(int heap);
    int pick, k, f, n, len;
    frame_run_t r;
    pick = $urandom_range(0, 99);
    if (pick < 45 || (pick < 85 && live_runs.size() == 0)) begin
      f = $urandom_range(0, 4095);
      k = $urandom_range(0, 9);
      if (heap == 0 || k == 9) n = $urandom_range(0, 8191);
      else if (k < 7) n = $urandom_range(1, (heap + 7) / 8);
      else n = $urandom_range(1, heap);
      queue_request(CMD_ALLOC, f, n);
    end else if (pick < 85) begin
      k = $urandom_range(0, live_runs.size() - 1);
      r = live_runs[k];
      live_runs.delete(k);
      len = r.count;
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, r.count);
        if (len < r.count) live_runs.push_back('{first: r.first + len, count: r.count - len});
      end
      queue_request(CMD_FREE, r.first, len);
    end else begin
      if (heap > 0 && $urandom_range(0, 1) == 0) begin
        f = $urandom_range(0, heap - 1);
        n = $urandom_range(0, 8);
      end else begin
        f = $urandom_range(0, 4095);
        n = $urandom_range(0, 8191);
      end
      queue_request(CMD_FREE, f, n);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (request_queue.size() != 0 || s_tvalid || awaited_replies.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_heap_frames(int value);
    int heap, i;
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= HEAP_W'(value);
    heap_frames_cfg = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    heap = (value > MAX_FRAMES) ? MAX_FRAMES : value;
    for (i = live_runs.size() - 1; i >= 0; i--)
      if (live_runs[i].first + live_runs[i].count > heap) live_runs.delete(i);
  endtask

  always @(negedge clk) begin : drive_requests
    frame_request_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_fire) begin
      if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = request_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, nxt.count, nxt.first};
        s_tuser  <= nxt.cmd;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_replies
    alloc_reply_t want;
    req_fire <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready)
        apply_frame_request(cmd_t'(s_tuser[0]), s_tdata[11:0], s_tdata[24:12]);
      if (m_tvalid && m_tready) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch($sformatf("reply with none awaited: status %0d start %0d",
                                    m_tdata[1:0], m_tdata[13:2]));
        end else begin
          want = awaited_replies.pop_front();
          if (m_tdata[1:0] !== want.status)
            report_mismatch($sformatf("status %0d, want %s", m_tdata[1:0], want.status.name()));
          if (m_tdata[13:2] !== want.start)
            report_mismatch($sformatf("start_frame %0d, want %0d", m_tdata[13:2], want.start));
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int p, k, heap;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_request(CMD_ALLOC, 0, 0);
    queue_request(CMD_ALLOC, 0, 4097);
    queue_request(CMD_ALLOC, 4095, 8191);
    queue_request(CMD_FREE, 0, 0);
    queue_request(CMD_FREE, 4095, 2);
    queue_request(CMD_FREE, 0, 1);
    queue_request(CMD_ALLOC, 0, 4096);
    queue_request(CMD_ALLOC, 0, 1);
    queue_request(CMD_FREE, 4095, 1);
    queue_request(CMD_FREE, 0, 4096);
    queue_request(CMD_FREE, 0, 4095);
    queue_request(CMD_ALLOC, 4095, 4000);
    queue_request(CMD_ALLOC, 0, 100);
    queue_request(CMD_ALLOC, 0, 96);
    queue_request(CMD_FREE, 0, 4000);
    queue_request(CMD_ALLOC, 0, 10);
    queue_request(CMD_ALLOC, 0, 4086);
    queue_request(CMD_FREE, 4000, 96);
    queue_request(CMD_ALLOC, 0, 3000);
    queue_request(CMD_ALLOC, 0, 2000);
    queue_request(CMD_ALLOC, 0, 500);
    queue_request(CMD_FREE, 10, 3000);
    queue_request(CMD_FREE, 0, 10);
    wait_drained();
    live_runs.delete();

    for (p = 0; p < 9; p++) begin
      case (p / 3)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_heap_frames(phase_heap[p]);
      heap = (phase_heap[p] > MAX_FRAMES) ? MAX_FRAMES : phase_heap[p];
      for (k = 0; k < phase_items[p]; k++) begin
        while (request_queue.size() >= 2) @(posedge clk);
        queue_random_request(heap);
      end
      wait_drained();
    end

    repeat (50) @(posedge clk);
    $display("Covered %0d requests over %0d heap sizes with sender, receiver and no idling:",
             request_total, 10);
    $display("  %0d allocated or freed, %0d out of space, %0d rejected, %0d unused-frame frees",
             status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_BAD],
             status_tally[ST_UNUSED]);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
